// ===== hdl/krt_pkg.sv =====
// Package for the keyed record table: sizes, operation and status codes,
// request, response and memory-entry types. Depends on nothing.
package krt_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam int KEY_W   = 32;
    localparam int PRICE_W = 23;
    localparam int HIDX_W  = 6;
    localparam int HELD_W  = 7;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;
    localparam logic [1:0] OP_DELETE = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOTFOUND  = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BADPRICE  = 3'd4;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] key;
        logic signed [23:0] price_cents;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [HIDX_W-1:0]  hit_index;
        logic [PRICE_W-1:0] hit_price;
        logic [HELD_W-1:0]  entries_held;
    } rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [PRICE_W-1:0] price;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Slot and count values are reduced to the widths of the result fields.
    function automatic logic [HIDX_W-1:0] idx_field(input logic [IDX_W-1:0] idx);
        logic [IDX_W+HIDX_W-1:0] wide;
        wide = {{HIDX_W{1'b0}}, idx};
        return wide[HIDX_W-1:0];
    endfunction

    function automatic logic [HELD_W-1:0] held_field(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+HELD_W-1:0] wide;
        wide = {{HELD_W{1'b0}}, cnt};
        return wide[HELD_W-1:0];
    endfunction

endpackage

// ===== hdl/keyed_record_table.sv =====
// Top level of the keyed record table: entry memory, sequencer and the
// output register. Depends on krt_pkg, krt_ram and krt_ctrl.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    krt_pkg::req_t (op, key, price)
//   m_        out        m_valid/m_ready    krt_pkg::rsp_t (status, slot, price, count)
//
// One item at a time. The scan reads one slot per cycle from the single read
// port until the key matches or every held entry has been read; a delete then
// moves each entry behind the match down one slot before the result is ready.
// Reset clears the entry count, the state and the valid flags; the memory needs no clearing pass.
// A result waits in the output register while m_ready is low; the next item
// is then taken but its result is held back until the register is free.
module keyed_record_table (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  krt_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output krt_pkg::rsp_t m_data
);
    logic                       ram_wr_en;
    logic [krt_pkg::IDX_W-1:0]  ram_wr_addr;
    krt_pkg::entry_t            ram_wr_data;
    logic                       ram_rd_en;
    logic [krt_pkg::IDX_W-1:0]  ram_rd_addr;
    krt_pkg::entry_t            ram_rd_data;
    logic                       rsp_done;
    krt_pkg::rsp_t              rsp;
    logic                       out_busy;
    logic                       m_valid_reg;
    krt_pkg::rsp_t              m_data_reg;

    assign out_busy = m_valid_reg && !m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    krt_ram #(
        .WIDTH (krt_pkg::ENTRY_W),
        .DEPTH (krt_pkg::CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    krt_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_valid),
        .req_ready   (s_ready),
        .req         (s_data),
        .rsp_done    (rsp_done),
        .rsp         (rsp),
        .out_busy    (out_busy),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rsp_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (rsp_done) begin
            m_data_reg <= rsp;
        end
    end

endmodule

// ===== hdl/krt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Depends on nothing.
module krt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                    aclk,
    input  logic                    wr_en,
    input  logic [ADDR_W-1:0]       wr_addr,
    input  logic [WIDTH-1:0]        wr_data,
    input  logic                    rd_en,
    input  logic [ADDR_W-1:0]       rd_addr,
    output logic [WIDTH-1:0]        rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/krt_ctrl.sv =====
// Sequencer of the keyed record table: scans the entry memory, then applies
// insert, update or the delete shift. Depends on krt_pkg and drives krt_ram.
module krt_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  krt_pkg::req_t                req,
    output logic                         rsp_done,
    output krt_pkg::rsp_t                rsp,
    input  logic                         out_busy,
    output logic                         ram_wr_en,
    output logic [krt_pkg::IDX_W-1:0]    ram_wr_addr,
    output krt_pkg::entry_t              ram_wr_data,
    output logic                         ram_rd_en,
    output logic [krt_pkg::IDX_W-1:0]    ram_rd_addr,
    input  krt_pkg::entry_t              ram_rd_data
);
    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_DONE} state_t;

    state_t                       state_reg, state_next;
    krt_pkg::req_t                req_reg, req_next;
    krt_pkg::rsp_t                rsp_reg, rsp_next;
    logic [krt_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [krt_pkg::CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                         cmp_vld_reg, cmp_vld_next;
    logic [krt_pkg::IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic [krt_pkg::CNT_W-1:0]    sh_rd_reg, sh_rd_next;
    logic                         sh_vld_reg, sh_vld_next;
    logic [krt_pkg::IDX_W-1:0]    sh_wr_reg, sh_wr_next;

    logic found_now;
    logic miss_end;
    logic neg_price;
    logic table_full;

    assign found_now  = cmp_vld_reg && (ram_rd_data.key == req_reg.key);
    assign miss_end   = !found_now && (rd_idx_reg >= count_reg);
    assign neg_price  = req_reg.price_cents[23];
    assign table_full = (count_reg == krt_pkg::CAP_CNT);

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_done  = (state_reg == S_DONE) && !out_busy;
    assign rsp       = rsp_reg;

    always_comb begin
        logic [krt_pkg::CNT_W-1:0] sh_prev;
        state_next   = state_reg;
        req_next     = req_reg;
        rsp_next     = rsp_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_vld_next = cmp_vld_reg;
        cmp_idx_next = cmp_idx_reg;
        sh_rd_next   = sh_rd_reg;
        sh_vld_next  = sh_vld_reg;
        sh_wr_next   = sh_wr_reg;
        sh_prev      = sh_rd_reg - krt_pkg::CNT_W'(1);
        ram_wr_en    = 1'b0;
        ram_wr_addr  = '0;
        ram_wr_data.key   = req_reg.key;
        ram_wr_data.price = req_reg.price_cents[krt_pkg::PRICE_W-1:0];
        ram_rd_en    = 1'b0;
        ram_rd_addr  = '0;

        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    req_next     = req;
                    rd_idx_next  = '0;
                    cmp_vld_next = 1'b0;
                    state_next   = S_SCAN;
                end
            end

            S_SCAN: begin
                // Reads run one slot ahead of the compare.
                if (rd_idx_reg < count_reg) begin
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = rd_idx_reg[krt_pkg::IDX_W-1:0];
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_idx_reg[krt_pkg::IDX_W-1:0];
                    rd_idx_next  = rd_idx_reg + krt_pkg::CNT_W'(1);
                end else begin
                    cmp_vld_next = 1'b0;
                end

                if (found_now || miss_end) begin
                    rsp_next.status       = krt_pkg::ST_OK;
                    rsp_next.hit_index    = '0;
                    rsp_next.hit_price    = '0;
                    rsp_next.entries_held = krt_pkg::held_field(count_reg);
                    state_next            = S_DONE;
                    case (req_reg.req_type)
                        krt_pkg::OP_LOOKUP: begin
                            if (found_now) begin
                                rsp_next.hit_index = krt_pkg::idx_field(cmp_idx_reg);
                                rsp_next.hit_price = ram_rd_data.price;
                            end else begin
                                rsp_next.status = krt_pkg::ST_NOTFOUND;
                            end
                        end
                        krt_pkg::OP_INSERT: begin
                            if (table_full) begin
                                rsp_next.status = krt_pkg::ST_FULL;
                            end else if (found_now) begin
                                rsp_next.status = krt_pkg::ST_DUPLICATE;
                            end else if (neg_price) begin
                                rsp_next.status = krt_pkg::ST_BADPRICE;
                            end else begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = count_reg[krt_pkg::IDX_W-1:0];
                                count_next  = count_reg + krt_pkg::CNT_W'(1);
                                rsp_next.hit_index =
                                    krt_pkg::idx_field(count_reg[krt_pkg::IDX_W-1:0]);
                                rsp_next.entries_held = krt_pkg::held_field(
                                    count_reg + krt_pkg::CNT_W'(1));
                            end
                        end
                        krt_pkg::OP_UPDATE: begin
                            if (!found_now) begin
                                rsp_next.status = krt_pkg::ST_NOTFOUND;
                            end else if (neg_price) begin
                                rsp_next.status = krt_pkg::ST_BADPRICE;
                            end else begin
                                ram_wr_en          = 1'b1;
                                ram_wr_addr        = cmp_idx_reg;
                                rsp_next.hit_index = krt_pkg::idx_field(cmp_idx_reg);
                            end
                        end
                        default: begin
                            if (!found_now) begin
                                rsp_next.status = krt_pkg::ST_NOTFOUND;
                            end else begin
                                rsp_next.hit_index = krt_pkg::idx_field(cmp_idx_reg);
                                rsp_next.entries_held = krt_pkg::held_field(
                                    count_reg - krt_pkg::CNT_W'(1));
                                sh_rd_next  = krt_pkg::CNT_W'(cmp_idx_reg)
                                            + krt_pkg::CNT_W'(1);
                                sh_vld_next = 1'b0;
                                state_next  = S_SHIFT;
                            end
                        end
                    endcase
                end
            end

            S_SHIFT: begin
                // Each entry read here is written one slot lower in the following cycle.
                if (sh_vld_reg) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = sh_wr_reg;
                    ram_wr_data = ram_rd_data;
                end
                if (sh_rd_reg < count_reg) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = sh_rd_reg[krt_pkg::IDX_W-1:0];
                    sh_vld_next = 1'b1;
                    sh_wr_next  = sh_prev[krt_pkg::IDX_W-1:0];
                    sh_rd_next  = sh_rd_reg + krt_pkg::CNT_W'(1);
                end else begin
                    sh_vld_next = 1'b0;
                    count_next  = count_reg - krt_pkg::CNT_W'(1);
                    state_next  = S_DONE;
                end
            end

            S_DONE: begin
                if (!out_busy) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            sh_vld_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
            sh_vld_reg  <= sh_vld_next;
        end
        req_reg     <= req_next;
        rsp_reg     <= rsp_next;
        rd_idx_reg  <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        sh_rd_reg   <= sh_rd_next;
        sh_wr_reg   <= sh_wr_next;
    end

endmodule

// ===== hdl/krt_chk.sv =====
// Port-level checker for the keyed record table and its bind to the top
// level. Depends on krt_pkg and keyed_record_table.
module krt_chk (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input krt_pkg::rsp_t m_data
);

    // A stalled result must hold.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // A refused request reports no slot and no price.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != krt_pkg::ST_OK)
        |-> (m_data.hit_index == '0) && (m_data.hit_price == '0))
        else $error("refused request carries slot or price");

    // The entry count never exceeds the table size.
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (krt_pkg::CNT_W'(m_data.entries_held) <= krt_pkg::CAP_CNT))
        else $error("entry count above capacity");

    // A result never appears in the cycle straight after an item is taken.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result too early");

endmodule

bind keyed_record_table krt_chk u_krt_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
